// ===== hdl/jsbe_pkg.sv =====
// ----------------------------------------------------------------------------
// JTAG bit-bang stream encoder: shared package
// Pin masks, status codes, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package jsbe_pkg;

    // Pin byte layout
    localparam logic [7:0] PIN_TCK = 8'h01;
    localparam logic [7:0] PIN_TMS = 8'h02;
    localparam logic [7:0] PIN_TDI = 8'h04;
    localparam logic [7:0] PIN_SMP = 8'h80;
    localparam int unsigned PIN_TDO_BIT = 3;

    // Input transaction kinds (carried on tuser)
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_SAMPLE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PIN        = 2'd0,
        ST_READ_OK    = 2'd1,
        ST_MISMATCH   = 2'd2,
        ST_UNEXPECTED = 2'd3
    } t_status;

    // Register map
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_BIT_REPEAT  = 1'b0;
    localparam logic REG_READBACK_EN = 1'b1;

    localparam int unsigned REPEAT_W = 6;
    localparam int unsigned COUNT_W  = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Queue entry: bit 0 expected TDO, bit 1 check flag
    typedef struct packed {
        logic check;
        logic tdo;
    } t_entry;

    typedef struct packed {
        logic [REPEAT_W-1:0] bit_repeat;
        logic                readback_en;
    } t_cfg;

endpackage

// ===== hdl/jsbe_cfg.sv =====
// ----------------------------------------------------------------------------
// JTAG bit-bang stream encoder: configuration registers
// APB-style register file holding bit_repeat and readback_enable.
// ----------------------------------------------------------------------------
module jsbe_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [jsbe_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]               i_pwdata,
    output logic [31:0]               o_prdata,
    output jsbe_pkg::t_cfg            o_cfg
);
    import jsbe_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en = i_psel && i_penable && i_pwrite;

    // Write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_repeat  <= REPEAT_W'(1);
            r_cfg.readback_en <= 1'b1;
        end else if (wr_en) begin
            unique case (i_paddr[2])
                REG_BIT_REPEAT:  r_cfg.bit_repeat  <= i_pwdata[REPEAT_W-1:0];
                REG_READBACK_EN: r_cfg.readback_en <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (i_paddr[2])
            REG_BIT_REPEAT:  o_prdata = {{(32-REPEAT_W){1'b0}}, r_cfg.bit_repeat};
            REG_READBACK_EN: o_prdata = {31'b0, r_cfg.readback_en};
            default:         o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/jsbe_queue.sv =====
// ----------------------------------------------------------------------------
// JTAG bit-bang stream encoder: expectation queue
// Circular buffer in a synchronous memory; pop data is registered.
// ----------------------------------------------------------------------------
module jsbe_queue #(
    parameter int unsigned DEPTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jsbe_pkg::t_entry i_push_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output jsbe_pkg::t_entry o_rd_data
);
    import jsbe_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

    t_entry         mem [DEPTH];
    logic [AW-1:0]  r_head;
    logic [AW-1:0]  r_tail;
    logic [FW-1:0]  r_fill;
    t_entry         r_rd_data;
    logic           push_do;
    logic           pop_do;

    assign o_full  = (r_fill == FILL_MAX);
    assign o_empty = (r_fill == '0);
    assign push_do = i_push && !o_full;
    assign pop_do  = i_pop && !o_empty;

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (push_do) begin
            mem[r_tail] <= i_push_data;
        end
        if (pop_do) begin
            r_rd_data <= mem[r_head];
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (push_do) begin
                r_tail <= (r_tail == PTR_LAST) ? '0 : r_tail + AW'(1);
            end
            if (pop_do) begin
                r_head <= (r_head == PTR_LAST) ? '0 : r_head + AW'(1);
            end
            if (push_do && !pop_do) begin
                r_fill <= r_fill + FW'(1);
            end else if (pop_do && !push_do) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

    assign o_rd_data = r_rd_data;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("queue fill above depth");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full && !i_pop) |=> ($stable(r_tail) && $stable(r_fill)))
        else $error("push into full queue moved tail");

    a_empty_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && o_empty && !i_push) |=> ($stable(r_head) && $stable(r_fill)))
        else $error("pop from empty queue moved head");
`endif

endmodule

// ===== hdl/jtag_serial_bitstream_encoder.sv =====
// ----------------------------------------------------------------------------
// JTAG bit-bang stream encoder: top level
// Accepted items are registered as the item in work, results in the output
// register. One result per cycle unless the output stalls; a command gives
// a TCK-low and a TCK-high run; a sample one. Next item taken with last result.
// Reset (synchronous, active low) clears pointers, counter, overflow flag and
// sets config to defaults; the queue memory is not cleared.
// ----------------------------------------------------------------------------
module jtag_serial_bitstream_encoder #(
    parameter int unsigned QUEUE_DEPTH = 4096,
    parameter int unsigned MAX_REPEAT  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: tms_bit[0], tdi_bit[1], expected_tdo[2], check_tdo[3],
    //        sample_byte[11:4], zero pad[15:12]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // tuser: action[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: pin_byte[7:0], mismatch_total[23:8], queue_overflowed[24],
    //        zero pad[31:25]
    output logic [31:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [jsbe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jsbe_pkg::*;

    localparam int unsigned CW = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;

    t_cfg            cfg;
    logic            acc;
    logic            acc_cmd;
    logic            acc_smp;
    logic            q_full;
    logic            q_empty;
    t_entry          q_rd;
    t_entry          in_entry;
    logic [REPEAT_W-1:0] rep_clamp;

    // Item in work
    logic            r_busy;
    logic            r_kind;
    logic            r_tms;
    logic            r_tdi;
    logic            r_half;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_rep_m1;
    logic            r_had_entry;
    logic            r_smp_tdo;

    // Shared state and output register
    logic [COUNT_W-1:0] r_mismatch;
    logic               r_ovf;
    logic               r_out_valid;
    logic [31:0]        r_out_data;
    t_status            r_out_status;
    logic               r_out_last;

    logic               last_in_half;
    logic               item_done;
    logic               load_ok;
    logic               fire;
    logic [7:0]         n_byte;
    t_status            n_status;
    logic [COUNT_W-1:0] n_mismatch;
    logic               n_last;

    assign pready = 1'b1;

    jsbe_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // Input transaction decode
    assign acc     = s_axis_tvalid && s_axis_tready;
    assign acc_cmd = acc && (s_axis_tuser == ACT_COMMAND);
    assign acc_smp = acc && (s_axis_tuser == ACT_SAMPLE);
    assign in_entry.tdo   = s_axis_tdata[2];
    assign in_entry.check = s_axis_tdata[3];

    jsbe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (acc_cmd && cfg.readback_en),
        .i_push_data (in_entry),
        .i_pop       (acc_smp),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .o_rd_data   (q_rd)
    );

    // Clamp repeat count to 1..MAX_REPEAT
    always_comb begin
        if (cfg.bit_repeat == '0) begin
            rep_clamp = REPEAT_W'(1);
        end else if (cfg.bit_repeat > REPEAT_W'(MAX_REPEAT)) begin
            rep_clamp = REPEAT_W'(MAX_REPEAT);
        end else begin
            rep_clamp = cfg.bit_repeat;
        end
    end

    // Build the next result from the item in work
    assign last_in_half = (r_cnt == r_rep_m1);

    always_comb begin
        n_byte   = '0;
        n_status = ST_PIN;
        n_last   = 1'b1;
        if (r_kind == ACT_SAMPLE) begin
            if (!r_had_entry) begin
                n_status = ST_UNEXPECTED;
            end else if (q_rd.check && (q_rd.tdo != r_smp_tdo)) begin
                n_status = ST_MISMATCH;
            end else begin
                n_status = ST_READ_OK;
            end
        end else begin
            n_byte = (r_tms ? PIN_TMS : 8'h00) | (r_tdi ? PIN_TDI : 8'h00);
            if (r_half) begin
                n_byte = n_byte | PIN_TCK;
            end else if (last_in_half) begin
                n_byte = n_byte | PIN_SMP;
            end
            n_last = r_half && last_in_half;
        end
    end

    assign item_done  = n_last;
    assign n_mismatch = ((n_status == ST_MISMATCH) && (r_mismatch != COUNT_MAX))
                        ? r_mismatch + COUNT_W'(1) : r_mismatch;

    assign load_ok       = !r_out_valid || m_axis_tready;
    assign fire          = r_busy && load_ok;
    assign s_axis_tready = !r_busy || (load_ok && item_done);

    // Load or advance the item in work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (acc) begin
            r_busy <= 1'b1;
        end else if (fire && item_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_kind      <= s_axis_tuser;
            r_tms       <= s_axis_tdata[0];
            r_tdi       <= s_axis_tdata[1];
            r_smp_tdo   <= s_axis_tdata[4 + PIN_TDO_BIT];
            r_had_entry <= !q_empty;
            r_half      <= 1'b0;
            r_cnt       <= '0;
            r_rep_m1    <= CW'(rep_clamp - REPEAT_W'(1));
        end else if (fire && !item_done) begin
            if (last_in_half) begin
                r_half <= 1'b1;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Hold mismatch counter and sticky overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mismatch <= '0;
            r_ovf      <= 1'b0;
        end else begin
            if (fire) begin
                r_mismatch <= n_mismatch;
            end
            if (acc_cmd && cfg.readback_en && q_full) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data   <= {7'b0, r_ovf, n_mismatch, n_byte};
            r_out_status <= n_status;
            r_out_last   <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    a_stall_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_mismatch))
        else $error("mismatch counter moved while output stalled");

    a_empty_read_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_smp && q_empty) |=> (r_busy && !r_had_entry))
        else $error("sample on empty queue not marked unexpected");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JTAG bit-bang stream encoder: testbench
// Sends JTAG command and sample-byte transactions, predicts the pin byte
// stream and the readback status, mismatch counter and overflow flag, and
// compares every output transaction against that prediction in order.
// ----------------------------------------------------------------------------
module testbench;
    import jsbe_pkg::*;

    localparam int unsigned QUEUE_DEPTH    = 4096;
    localparam int unsigned MAX_REPEAT     = 32;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned TAIL_CYCLES    = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT    = 40;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    // One input transaction, fields as the predictor sees them
    typedef struct packed {
        logic       act;
        logic       tms;
        logic       tdi;
        logic       etdo;
        logic       chk;
        logic [7:0] smp;
    } t_item;

    // One expected output transaction
    typedef struct packed {
        logic [7:0]         pin;
        logic               last;
        t_status            status;
        logic [COUNT_W-1:0] total;
        logic               ovf;
    } t_beat;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = ACT_COMMAND;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state
    t_entry             tdo_expect_q[$];
    t_beat              pending_beats[$];
    logic [COUNT_W-1:0] mismatch_model = '0;
    logic               overflow_model = 1'b0;
    logic [REPEAT_W-1:0] cfg_repeat    = 6'd1;
    logic               cfg_rb_en      = 1'b1;

    // Traffic shaping
    t_rx_mode rx_mode     = RX_RANDOM;
    int unsigned rx_cycle = 0;
    bit       tx_bursty   = 1'b1;
    int unsigned burst_left = 0;

    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;
    t_beat       beat_want;

    jtag_serial_bitstream_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Generate a 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Advance the predictor by one accepted input transaction
    function automatic void encode_item(t_item it);
        int unsigned rep;
        logic [7:0]  low;
        t_entry      ent;
        t_status     st;
        if (it.act == ACT_COMMAND) begin
            rep = 32'(cfg_repeat);
            if (rep == 0)
                rep = 1;
            if (rep > MAX_REPEAT)
                rep = MAX_REPEAT;
            if (cfg_rb_en) begin
                if (tdo_expect_q.size() >= QUEUE_DEPTH)
                    overflow_model = 1'b1;
                else
                    tdo_expect_q.push_back('{check: it.chk, tdo: it.etdo});
            end
            low = (it.tms ? PIN_TMS : 8'h00) | (it.tdi ? PIN_TDI : 8'h00);
            for (int unsigned r = 0; r < rep; r++)
                pending_beats.push_back('{(r == rep - 1) ? (low | PIN_SMP) : low, 1'b0,
                                          ST_PIN, mismatch_model, overflow_model});
            for (int unsigned r = 0; r < rep; r++)
                pending_beats.push_back('{low | PIN_TCK, (r == rep - 1), ST_PIN,
                                          mismatch_model, overflow_model});
        end else if (tdo_expect_q.size() == 0) begin
            pending_beats.push_back('{8'h00, 1'b1, ST_UNEXPECTED, mismatch_model,
                                      overflow_model});
        end else begin
            ent = tdo_expect_q.pop_front();
            st  = ST_READ_OK;
            if (ent.check && (it.smp[PIN_TDO_BIT] != ent.tdo)) begin
                st = ST_MISMATCH;
                if (mismatch_model != COUNT_MAX)
                    mismatch_model++;
            end
            pending_beats.push_back('{8'h00, 1'b1, st, mismatch_model, overflow_model});
        end
    endfunction

    // Drive one input transaction and wait for its handshake
    task automatic send_item(t_item it);
        int unsigned gap;
        if (tx_bursty && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.act;
        s_axis_tdata  <= {4'h0, it.smp, it.chk, it.etdo, it.tdi, it.tms};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        encode_item(it);
    endtask

    task automatic send_command(logic tms, logic tdi, logic etdo, logic chk);
        logic [7:0] junk;
        junk = 8'($urandom);
        send_item('{ACT_COMMAND, tms, tdi, etdo, chk, junk});
    endtask

    task automatic send_sample(logic [7:0] smp);
        logic [3:0] junk;
        junk = 4'($urandom);
        send_item('{ACT_SAMPLE, junk[0], junk[1], junk[2], junk[3], smp});
    endtask

    // Hold the stream idle until every expected result has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready
    task automatic apb_access(logic wr, logic reg_idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register once the block is idle, then read it back
    task automatic set_register(logic reg_idx, logic [31:0] value);
        logic [31:0] junk;
        logic [31:0] wdata;
        logic [31:0] rd;
        logic [31:0] want;
        junk = $urandom;
        wait_drained();
        if (reg_idx == REG_BIT_REPEAT) begin
            wdata      = {junk[31:REPEAT_W], value[REPEAT_W-1:0]};
            cfg_repeat = value[REPEAT_W-1:0];
            want       = 32'(cfg_repeat);
        end else begin
            wdata     = {junk[31:1], value[0]};
            cfg_rb_en = value[0];
            want      = 32'(cfg_rb_en);
        end
        apb_access(1'b1, reg_idx, wdata, rd);
        apb_access(1'b0, reg_idx, '0, rd);
        if (rd !== want)
            report_mismatch("register readback", rd, want);
    endtask

    task automatic test_register_defaults();
        logic [31:0] rd;
        apb_access(1'b0, REG_BIT_REPEAT, '0, rd);
        if (rd !== 32'd1)
            report_mismatch("bit_repeat after reset", rd, 32'd1);
        apb_access(1'b0, REG_READBACK_EN, '0, rd);
        if (rd !== 32'd1)
            report_mismatch("readback_enable after reset", rd, 32'd1);
    endtask

    // All TMS/TDI levels with the reset configuration
    task automatic test_pin_encoding();
        rx_mode = RX_ALWAYS;
        send_command(1'b0, 1'b0, 1'b0, 1'b1);
        send_command(1'b1, 1'b0, 1'b1, 1'b1);
        send_command(1'b0, 1'b1, 1'b0, 1'b0);
        send_command(1'b1, 1'b1, 1'b1, 1'b0);
    endtask

    // Match, mismatch, unchecked entries, then readback with the queue empty
    task automatic test_readback_status();
        rx_mode = RX_PERIODIC;
        send_sample(8'h00);
        send_sample(8'hF7);
        send_sample(8'hFF);
        send_sample(8'h08);
        send_sample(8'hFF);
    endtask

    // Repeat zero, minimum, maximum and above maximum
    task automatic test_repeat_limits();
        logic [5:0] reps[5];
        logic [2:0] junk;
        reps = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
        rx_mode = RX_RANDOM;
        foreach (reps[i]) begin
            set_register(REG_BIT_REPEAT, 32'(reps[i]));
            junk = 3'($urandom);
            send_command(junk[0], junk[1], junk[2], 1'b1);
        end
        for (int i = 0; i < 5; i++)
            send_sample(8'($urandom));
    endtask

    // Disabled readback still pops entries queued earlier
    task automatic test_readback_disabled();
        set_register(REG_BIT_REPEAT, 32'd2);
        send_command(1'b1, 1'b0, 1'b1, 1'b1);
        set_register(REG_READBACK_EN, 32'd0);
        send_command(1'b0, 1'b1, 1'b0, 1'b1);
        send_command(1'b1, 1'b1, 1'b0, 1'b1);
        send_sample(8'h08);
        send_sample(8'h00);
        set_register(REG_READBACK_EN, 32'd1);
    endtask

    // Mostly command/sample pairs with random content, some stray items
    task automatic test_random_traffic();
        int unsigned n;
        int unsigned pick;
        logic        etdo;
        logic        chk;
        logic [7:0]  smp;
        logic [3:0]  junk;
        bit          paused;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    set_register(REG_BIT_REPEAT, $urandom_range(1, 4));
                    set_register(REG_READBACK_EN, 32'd1);
                    rx_mode = RX_RANDOM;
                    tx_bursty = 1'b1;
                end
                1: begin
                    set_register(REG_BIT_REPEAT, 32'd32);
                    rx_mode = RX_PERIODIC;
                end
                2: begin
                    set_register(REG_BIT_REPEAT, 32'd0);
                    set_register(REG_READBACK_EN, 32'd0);
                    rx_mode = RX_ALWAYS;
                    tx_bursty = 1'b0;
                end
                default: begin
                    set_register(REG_BIT_REPEAT, $urandom_range(0, 63));
                    set_register(REG_READBACK_EN, 32'($urandom_range(0, 3) != 0));
                    rx_mode = RX_RANDOM;
                    tx_bursty = 1'b1;
                end
            endcase
            n = 0;
            paused = 1'b0;
            while (n < 24) begin
                pick = $urandom_range(0, 9);
                junk = 4'($urandom);
                if (pick < 8) begin
                    etdo = 1'($urandom);
                    chk  = $urandom_range(0, 3) != 0;
                    send_command(junk[0], junk[1], etdo, chk);
                    smp = 8'($urandom);
                    smp[PIN_TDO_BIT] = ($urandom_range(0, 3) != 0) ? etdo : ~etdo;
                    send_sample(smp);
                    n += 2;
                end else if (pick == 8) begin
                    send_command(junk[0], junk[1], junk[2], junk[3]);
                    n++;
                end else begin
                    send_sample(8'($urandom));
                    n++;
                end
                // Hold off mid-phase until the output side has caught up
                if (n >= 12 && !paused) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // Build up a backlog of expectations, then drain it past empty
    task automatic test_queue_backlog();
        int unsigned cnt;
        logic [3:0]  junk;
        set_register(REG_BIT_REPEAT, 32'd1);
        set_register(REG_READBACK_EN, 32'd1);
        rx_mode = RX_PERIODIC;
        tx_bursty = 1'b1;
        repeat (12) begin
            junk = 4'($urandom);
            send_command(junk[0], junk[1], junk[2], junk[3]);
        end
        rx_mode = RX_RANDOM;
        cnt = tdo_expect_q.size() + 2;
        repeat (cnt) send_sample(8'($urandom));
    endtask

    // Accumulate a run of checked TDO mismatches in the counter
    task automatic test_mismatch_count();
        logic [7:0] junk;
        set_register(REG_BIT_REPEAT, 32'd1);
        set_register(REG_READBACK_EN, 32'd1);
        rx_mode = RX_ALWAYS;
        tx_bursty = 1'b0;
        repeat (8) begin
            junk = 8'($urandom);
            send_command(junk[0], junk[1], 1'b0, 1'b1);
            send_sample(8'h08 | junk);
        end
    endtask

    // Stall the output side on a pattern of its own
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_mode)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:     m_axis_tready <= ((rx_cycle % 7) < 4);
        endcase
    end

    // Compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata, 32'h0);
            end else begin
                beat_want = pending_beats.pop_front();
                if (m_axis_tdata[7:0] !== beat_want.pin)
                    report_mismatch("pin_byte", 32'(m_axis_tdata[7:0]),
                                    32'(beat_want.pin));
                if (m_axis_tlast !== beat_want.last)
                    report_mismatch("last_of_run", 32'(m_axis_tlast), 32'(beat_want.last));
                if (m_axis_tuser !== beat_want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(beat_want.status));
                if (m_axis_tdata[23:8] !== beat_want.total)
                    report_mismatch("mismatch_total", 32'(m_axis_tdata[23:8]),
                                    32'(beat_want.total));
                if (m_axis_tdata[24] !== beat_want.ovf)
                    report_mismatch("queue_overflowed", 32'(m_axis_tdata[24]),
                                    32'(beat_want.ovf));
                if (m_axis_tdata[31:25] !== 7'h00)
                    report_mismatch("tdata pad", 32'(m_axis_tdata[31:25]), 32'h0);
            end
        end
    end

    // End the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_defaults();
        test_pin_encoding();
        test_readback_status();
        test_repeat_limits();
        test_readback_disabled();
        test_random_traffic();
        test_queue_backlog();
        test_mismatch_count();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/jsbe_pkg.sv
hdl/jsbe_cfg.sv
hdl/jsbe_queue.sv
hdl/jtag_serial_bitstream_encoder.sv
test/testbench.sv
